// ===== rtl/fle_pkg.sv =====
// Shared types and constants for the fractional LMS equalizer.
`default_nettype none
package fle_pkg;

    localparam int TAPS     = 15;
    localparam int SAMPLE_W = 16;
    localparam int WEIGHT_W = 24;
    localparam int OUT_W    = 18;
    localparam int STEP_W   = 16;
    localparam int MAC_W    = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W    = MAC_W + $clog2(TAPS);
    localparam int ES_W     = OUT_W + STEP_W + 1;
    localparam int UPD_W    = ES_W + SAMPLE_W;
    localparam int DELTA_W  = UPD_W - 26;
    localparam int MAC_CYCLES = TAPS + 2;
    localparam int CNT_W    = $clog2(MAC_CYCLES + 1);

    localparam logic [1:0] REG_SYMBOL_WIDTH   = 2'd0;
    localparam logic [1:0] REG_DECISION_PHASE = 2'd1;
    localparam logic [1:0] REG_STEP_SIZE      = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MAC,
        ST_FIN,
        ST_PUSH,
        ST_UPD1,
        ST_UPD2
    } state_t;

    typedef struct packed {
        logic shift;
        logic write;
    } cell_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/fractional_lms_equalizer_core.sv =====
// Top level: LMS-trained fractionally spaced equalizer built from a chain of tap cells.
// A sample that is no symbol point only shifts into the taps and gives no result; a
// symbol point shows its result after the MAC, finish and push states (partial sums
// ripple one cell per cycle). Non-symbol samples are accepted back to back; after a
// symbol point no sample is taken until the core is idle again, and with adaptation
// the ST_UPD1 and ST_UPD2 weight-update states follow the result; longer if the output stalls.
// Reset: asynchronous active low; clears taps, weights, phase and restores registers.
`default_nettype none
module fractional_lms_equalizer_core
    import fle_pkg::*;
(
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [39:0] s_tdata,   // sample[15:0], train_value[31:16], adapt[32], zero pad
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata,   // equalized[17:0], error_value[35:18], zero pad
    input  wire         cfg_we,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);

    state_t state_reg, state_next;

    logic [4:0]          sym_width_reg;
    logic [3:0]          dec_phase_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [3:0]          phase_reg;
    logic [CNT_W-1:0]    cnt_reg;
    logic signed [15:0]  train_reg;
    logic                adapt_reg;
    logic signed [OUT_W-1:0] y_reg;
    logic signed [ES_W-1:0]  es_reg;
    logic                m_valid_reg;
    logic signed [OUT_W-1:0] m_y_reg;
    logic signed [OUT_W-1:0] m_err_reg;

    logic                accept;
    logic                load_out;
    logic [4:0]          sw_eff;
    logic [4:0]          phase_cur;
    logic [4:0]          phase_inc;
    logic                hit;
    logic [3:0]          phase_next;
    cell_ctrl_t          ctrl;

    logic signed [SAMPLE_W-1:0] tap_chain [TAPS+1];
    logic signed [ACC_W-1:0]    psum_chain [TAPS+1];

    logic signed [ACC_W-1:0]    acc_round;
    logic signed [ACC_W-21:0]   y_wide;
    logic signed [OUT_W-1:0]    y_sat;
    logic signed [OUT_W:0]      err_wide;
    logic signed [OUT_W-1:0]    err_sat;

    assign accept = s_tvalid && s_tready;

    // Phase tracking
    always_comb
    begin
        if (sym_width_reg == 5'd0)
            sw_eff = 5'd1;
        else if (sym_width_reg > 5'd16)
            sw_eff = 5'd16;
        else
            sw_eff = sym_width_reg;
        phase_cur = ({1'b0, phase_reg} >= sw_eff) ? 5'd0 : {1'b0, phase_reg};
        hit       = (phase_cur == {1'b0, dec_phase_reg});
        phase_inc = phase_cur + 5'd1;
        phase_next = (phase_inc >= sw_eff) ? 4'd0 : phase_inc[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sym_width_reg <= 5'd2;
            dec_phase_reg <= 4'd1;
            step_reg      <= 16'd655;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SYMBOL_WIDTH:   sym_width_reg <= cfg_data[4:0];
                REG_DECISION_PHASE: dec_phase_reg <= cfg_data[3:0];
                REG_STEP_SIZE:      step_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Control state machine
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        s_tready   = 1'b0;
        load_out   = 1'b0;
        ctrl.shift = 1'b0;
        ctrl.write = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                s_tready   = 1'b1;
                ctrl.shift = s_tvalid;
                if (s_tvalid && hit)
                    state_next = ST_MAC;
            end
            ST_MAC:
            begin
                if (cnt_reg == CNT_W'(MAC_CYCLES - 1))
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = adapt_reg ? ST_UPD1 : ST_IDLE;
                end
            end
            ST_UPD1:
            begin
                state_next = ST_UPD2;
            end
            ST_UPD2:
            begin
                ctrl.write = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg <= phase_next;
                cnt_reg   <= '0;
            end
            else if (state_reg == ST_MAC)
                cnt_reg <= cnt_reg + CNT_W'(1);
            if (load_out)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // Round, saturate and form the error
    always_comb
    begin
        acc_round = psum_chain[TAPS] + (ACC_W'(1) <<< 19);
        y_wide    = acc_round[ACC_W-1:20];
        if (y_wide > (ACC_W-20)'(131071))
            y_sat = 18'sh1FFFF;
        else if (y_wide < -(ACC_W-20)'(131072))
            y_sat = 18'sh20000;
        else
            y_sat = y_wide[OUT_W-1:0];
        err_wide = (OUT_W+1)'(train_reg) - (OUT_W+1)'(y_reg);
        if (err_wide > (OUT_W+1)'(131071))
            err_sat = 18'sh1FFFF;
        else if (err_wide < -(OUT_W+1)'(131072))
            err_sat = 18'sh20000;
        else
            err_sat = err_wide[OUT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            train_reg <= s_tdata[31:16];
            adapt_reg <= s_tdata[32];
        end
        if (state_reg == ST_FIN)
            y_reg <= y_sat;
        if (state_reg == ST_PUSH)
            es_reg <= err_sat * $signed({1'b0, step_reg});
        if (load_out)
        begin
            m_y_reg   <= y_reg;
            m_err_reg <= err_sat;
        end
    end

    // Cell chain
    assign tap_chain[0]  = s_tdata[15:0];
    assign psum_chain[0] = '0;

    genvar gi;
    generate
        for (gi = 0; gi < TAPS; gi++)
        begin : g_cell
            fle_cell u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (ctrl),
                .tap_in   (tap_chain[gi]),
                .tap_out  (tap_chain[gi+1]),
                .psum_in  (psum_chain[gi]),
                .psum_out (psum_chain[gi+1]),
                .es       (es_reg)
            );
        end
    endgenerate

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {4'd0, m_err_reg, m_y_reg};

endmodule
`default_nettype wire

// ===== rtl/fle_cell.sv =====
// One equalizer cell: a tap, its weight, a product stage, a partial-sum stage and its weight update.
`default_nettype none
module fle_cell
    import fle_pkg::*;
(
    input  wire                        clk,
    input  wire                        rst_n,
    input  cell_ctrl_t                 ctrl,
    input  wire  signed [SAMPLE_W-1:0] tap_in,
    output logic signed [SAMPLE_W-1:0] tap_out,
    input  wire  signed [ACC_W-1:0]    psum_in,
    output logic signed [ACC_W-1:0]    psum_out,
    input  wire  signed [ES_W-1:0]     es
);

    logic signed [SAMPLE_W-1:0] tap_reg;
    logic signed [WEIGHT_W-1:0] weight_reg;
    logic signed [WEIGHT_W-1:0] weight_next;
    logic signed [MAC_W-1:0]    mac_reg;
    logic signed [ACC_W-1:0]    psum_reg;
    logic signed [UPD_W-1:0]    upd_reg;
    logic signed [UPD_W-1:0]    upd_round;
    logic signed [DELTA_W-1:0]  delta;
    logic signed [WEIGHT_W+1:0] wsum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_reg    <= '0;
            weight_reg <= '0;
        end
        else
        begin
            if (ctrl.shift)
                tap_reg <= tap_in;
            if (ctrl.write)
                weight_reg <= weight_next;
        end
    end

    // Free-running product and partial-sum stages; hold valid while taps are still.
    always_ff @(posedge clk)
    begin
        mac_reg  <= tap_reg * weight_reg;
        psum_reg <= psum_in + ACC_W'(mac_reg);
        upd_reg  <= es * tap_reg;
    end

    always_comb
    begin
        upd_round = upd_reg + (UPD_W'(1) <<< 25);
        delta     = upd_round[UPD_W-1:26];
        wsum      = (WEIGHT_W+2)'(weight_reg) + (WEIGHT_W+2)'(delta);
        if (wsum > (WEIGHT_W+2)'(8388607))
            weight_next = 24'sh7FFFFF;
        else if (wsum < -(WEIGHT_W+2)'(8388608))
            weight_next = 24'sh800000;
        else
            weight_next = wsum[WEIGHT_W-1:0];
    end

    assign tap_out  = tap_reg;
    assign psum_out = psum_reg;

endmodule
`default_nettype wire
